FILE: rtl/pcx_rle_pkg.sv
// Shared constants, codes and helper functions for the PCX run-length decoder.
`timescale 1ns / 1ps

package pcx_rle_pkg;

   // Field widths of the channels
   localparam int CMD_W       = 2;
   localparam int BYTE_W      = 8;
   localparam int RGB_W       = 24;
   localparam int COLOR_W     = 16;
   localparam int COORD_W     = 10;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 11;
   localparam int RUN_LEN_W   = 6;
   localparam int PAL_DEPTH   = 256;

   // Defaults for the size parameters and the dimension registers
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int DIM_RESET      = 1024;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_DATA      = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PALETTE   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_NEW_IMAGE = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   // Run marker: both top bits set, count in the low six bits
   localparam logic [BYTE_W-1:0] RUN_MARK       = 8'hc0;
   localparam logic [BYTE_W-1:0] RUN_COUNT_MASK = 8'h3f;

   function automatic logic [COLOR_W-1:0] to_rgb565(input logic [BYTE_W-1:0] r,
                                                    input logic [BYTE_W-1:0] g,
                                                    input logic [BYTE_W-1:0] b);
      to_rgb565 = {r[7:3], g[7:2], b[7:3]};
   endfunction

endpackage

FILE: rtl/pcx_rle_if.sv
// Channel interfaces of the PCX decoder: request, pixel response and register write.
`timescale 1ns / 1ps

interface pcx_rle_req_if import pcx_rle_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [BYTE_W-1:0]   data_byte;
   logic [BYTE_W-1:0]   palette_index;
   logic [RGB_W-1:0]    palette_rgb;

   modport source (output valid, command, data_byte, palette_index, palette_rgb,
                   input ready);
   modport sink (input valid, command, data_byte, palette_index, palette_rgb,
                 output ready);
endinterface

interface pcx_rle_rsp_if import pcx_rle_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [COLOR_W-1:0]  pixel_color;
   logic [COORD_W-1:0]  pixel_column;
   logic [COORD_W-1:0]  pixel_row;
   logic                last_of_run;
   logic                image_done;

   modport source (output valid, pixel_color, pixel_column, pixel_row, last_of_run,
                   image_done, input ready);
   modport sink (input valid, pixel_color, pixel_column, pixel_row, last_of_run,
                 image_done, output ready);
endinterface

interface pcx_rle_csr_if import pcx_rle_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink (input valid, reg_index, wdata, output ready);
endinterface

FILE: rtl/pcx_rle_image_decoder_top.sv
// PCX run-length image decoder: byte stream in, RGB565 pixels out.
//
// req_chan takes one item per transaction: a compressed data byte, a palette entry
// write or a new-image command. rsp_chan delivers decoded pixels with their column,
// row, a last-of-run flag and an image-done flag. csr_chan writes color_mode,
// image_width and image_height; it is always ready. It is to be written between
// images by the user; the block does not enforce this. req_chan.ready is high
// only while the sequencer is idle. A palette write, a new-image command, a run
// marker or a byte past the image end is handled while idle. Palette mode: each
// pixel of a literal or run passes the step and emit states. 24-bit mode: each red
// or green plane byte is stored in the step state; a blue byte adds a green read
// state, as red and green are read in turn through the single read port of the
// plane memory. A line left too long by a register change takes an extra step to
// close. The pixel leaves through an output register, so the next item is taken
// while the last pixel of a run waits. When the receiver stalls with a pixel still
// to be produced, the sequencer holds until the output register frees up.
// Reset (synchronous) clears the position, row and run state, sets 8-bit palette
// mode and a 1024 x 1024 image (clamped to the size parameters). The palette and
// plane memories are not cleared and are valid only where written.
`timescale 1ns / 1ps

module pcx_rle_image_decoder_top import pcx_rle_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic          clock,
   input  logic          reset,
   pcx_rle_req_if.sink   req_chan,
   pcx_rle_rsp_if.source rsp_chan,
   pcx_rle_csr_if.sink   csr_chan
);

   localparam int WID_W   = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W   = $clog2(MAX_HEIGHT + 1);
   localparam int POS_W   = $clog2(3 * MAX_WIDTH + 1);
   localparam int PLANE_D = 2 * MAX_WIDTH;
   localparam int PA_W    = $clog2(PLANE_D);
   localparam int W_RST   = (DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET;
   localparam int H_RST   = (DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_STEP = 4'b0010,
      ST_RDG  = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   // Control registers
   state_type              state_ff, state_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic                   run_pend_ff, run_pend_in;
   logic [RUN_LEN_W-1:0]   run_len_ff, run_len_in;
   logic [RUN_LEN_W-1:0]   count_ff, count_in;
   logic                   mode_ff, mode_in;
   logic [WID_W-1:0]       w_ff, w_in;
   logic [ROW_W-1:0]       h_ff, h_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [BYTE_W-1:0]      value_ff, value_in;
   logic [POS_W-1:0]       col_ff, col_in;
   logic [BYTE_W-1:0]      red_ff, red_in;
   logic [COLOR_W-1:0]     color_ff;
   logic [COORD_W-1:0]     col_out_ff;
   logic [COORD_W-1:0]     row_out_ff;
   logic                   last_ff;
   logic                   done_ff;

   // Datapath
   logic [POS_W-1:0]       w_pos, w2_pos, linelen, pos_inc;
   logic [ROW_W-1:0]       row_inc;
   logic                   pos_over, line_end, last_row, in_blue;
   logic                   req_fire, csr_fire, out_free, load_out, advance;
   logic                   pix_last, pix_done;
   logic [COLOR_W-1:0]     pix_color;

   // Memories
   logic                   pal_we, pal_re;
   logic [RGB_W-1:0]       pal_rdata;
   logic                   plane_we, plane_re;
   logic [PA_W-1:0]        plane_waddr, plane_raddr;
   logic [BYTE_W-1:0]      plane_rdata;

   pcx_rle_ram #(
      .WIDTH (RGB_W),
      .DEPTH (PAL_DEPTH)
   ) u_palette (
      .clock (clock),
      .we    (pal_we),
      .waddr (req_chan.palette_index),
      .wdata (req_chan.palette_rgb),
      .re    (pal_re),
      .raddr (req_chan.data_byte),
      .rdata (pal_rdata)
   );

   pcx_rle_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (PLANE_D)
   ) u_plane (
      .clock (clock),
      .we    (plane_we),
      .waddr (plane_waddr),
      .wdata (value_ff),
      .re    (plane_re),
      .raddr (plane_raddr),
      .rdata (plane_rdata)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign csr_fire       = csr_chan.valid;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign pal_we = req_fire && (req_chan.command == CMD_PALETTE);
   // palette read data holds for the whole run: nothing else reads it meanwhile
   assign pal_re = req_fire && (req_chan.command == CMD_DATA);

   // Line geometry and position arithmetic, shared by every step
   assign w_pos    = POS_W'(w_ff);
   assign w2_pos   = w_pos << 1;
   assign linelen  = mode_ff ? (w2_pos + w_pos) : w_pos;
   assign pos_over = (pos_ff >= linelen);
   assign pos_inc  = pos_ff + POS_W'(1);
   assign line_end = (pos_inc >= linelen);
   assign row_inc  = row_ff + ROW_W'(1);
   assign last_row = (row_inc >= h_ff);
   assign in_blue  = (pos_ff >= w2_pos);

   assign pix_color = mode_ff ? to_rgb565(red_ff, plane_rdata, value_ff)
                              : to_rgb565(pal_rdata[23:16], pal_rdata[15:8], pal_rdata[7:0]);
   assign pix_last  = (count_ff == RUN_LEN_W'(1)) || line_end;
   assign pix_done  = line_end && last_row;

   // Configuration writes, dimensions clamped to 1..MAX
   always_comb begin
      mode_in = mode_ff;
      w_in    = w_ff;
      h_in    = h_ff;
      if (csr_fire) begin
         unique case (csr_chan.reg_index)
            CSR_COLOR_MODE: begin
               mode_in = csr_chan.wdata[0];
            end
            CSR_IMAGE_WIDTH: begin
               if (csr_chan.wdata == '0) begin
                  w_in = WID_W'(1);
               end else if (csr_chan.wdata > MAX_WIDTH) begin
                  w_in = WID_W'(MAX_WIDTH);
               end else begin
                  w_in = WID_W'(csr_chan.wdata);
               end
            end
            CSR_IMAGE_HEIGHT: begin
               if (csr_chan.wdata == '0) begin
                  h_in = ROW_W'(1);
               end else if (csr_chan.wdata > MAX_HEIGHT) begin
                  h_in = ROW_W'(MAX_HEIGHT);
               end else begin
                  h_in = ROW_W'(csr_chan.wdata);
               end
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      row_in      = row_ff;
      run_pend_in = run_pend_ff;
      run_len_in  = run_len_ff;
      count_in    = count_ff;
      value_in    = value_ff;
      col_in      = col_ff;
      red_in      = red_ff;
      plane_we    = 1'b0;
      plane_re    = 1'b0;
      plane_waddr = PA_W'(pos_ff);
      plane_raddr = PA_W'(col_ff);
      load_out    = 1'b0;
      advance     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_chan.command == CMD_NEW_IMAGE) begin
                  pos_in      = '0;
                  row_in      = '0;
                  run_pend_in = 1'b0;
                  run_len_in  = '0;
               end else if (req_chan.command == CMD_DATA && row_ff < h_ff) begin
                  value_in = req_chan.data_byte;
                  if (run_pend_ff) begin
                     run_pend_in = 1'b0;
                     count_in    = run_len_ff;
                     if (run_len_ff != '0) begin
                        state_in = ST_STEP;
                     end
                  end else if ((req_chan.data_byte & RUN_MARK) == RUN_MARK) begin
                     run_pend_in = 1'b1;
                     run_len_in  = RUN_LEN_W'(req_chan.data_byte & RUN_COUNT_MASK);
                  end else begin
                     count_in = RUN_LEN_W'(1);
                     state_in = ST_STEP;
                  end
               end
            end
         end
         ST_STEP: begin
            if (pos_over) begin
               // line already complete after a register change
               pos_in   = '0;
               row_in   = row_inc;
               state_in = last_row ? ST_IDLE : ST_STEP;
            end else if (!mode_ff) begin
               col_in   = pos_ff;
               state_in = ST_EMIT;
            end else if (!in_blue) begin
               plane_we = 1'b1;
               advance  = 1'b1;
            end else begin
               col_in      = pos_ff - w2_pos;
               plane_re    = 1'b1;
               plane_raddr = PA_W'(pos_ff - w2_pos);
               state_in    = ST_RDG;
            end
         end
         ST_RDG: begin
            red_in      = plane_rdata;
            plane_re    = 1'b1;
            plane_raddr = PA_W'(col_ff + w_pos);
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               load_out = 1'b1;
               advance  = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (advance) begin
         count_in = count_ff - RUN_LEN_W'(1);
         if (line_end) begin
            pos_in = '0;
            row_in = row_inc;
         end else begin
            pos_in = pos_inc;
         end
         state_in = pix_last ? ST_IDLE : ST_STEP;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         row_ff       <= '0;
         run_pend_ff  <= 1'b0;
         run_len_ff   <= '0;
         count_ff     <= '0;
         mode_ff      <= 1'b0;
         w_ff         <= WID_W'(W_RST);
         h_ff         <= ROW_W'(H_RST);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         row_ff       <= row_in;
         run_pend_ff  <= run_pend_in;
         run_len_ff   <= run_len_in;
         count_ff     <= count_in;
         mode_ff      <= mode_in;
         w_ff         <= w_in;
         h_ff         <= h_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      col_ff   <= col_in;
      red_ff   <= red_in;
      if (load_out) begin
         color_ff   <= pix_color;
         col_out_ff <= COORD_W'(col_ff);
         row_out_ff <= COORD_W'(row_ff);
         last_ff    <= pix_last;
         done_ff    <= pix_done;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.pixel_color  = color_ff;
   assign rsp_chan.pixel_column = col_out_ff;
   assign rsp_chan.pixel_row    = row_out_ff;
   assign rsp_chan.last_of_run  = last_ff;
   assign rsp_chan.image_done   = done_ff;

   // A run in progress always has pixels or plane bytes left to place
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (count_ff != '0))
      else $error("sequencer busy with an empty run count");

   // The final pixel of an image also closes the byte that produced it
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && done_ff) |-> last_ff)
      else $error("image_done without last_of_run");

   // A new-image command rewinds the line position and row
   a_new_image: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.command == CMD_NEW_IMAGE) |=> (pos_ff == '0 && row_ff == '0))
      else $error("new image did not clear the position");

   // The plane memory is only written in 24-bit mode
   a_plane_mode: assert property (@(posedge clock) disable iff (reset)
      plane_we |-> mode_ff)
      else $error("plane write in palette mode");

   // A pixel is only loaded when the output register is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !load_out)
      else $error("pending pixel overwritten");

endmodule

FILE: rtl/pcx_rle_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module pcx_rle_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the PCX run-length decoder: random byte streams vs. a pixel predictor.
`timescale 1ns / 1ps

module tb_top;
   import pcx_rle_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int QUIET_CYCLES = 300;
   localparam int RANDOM_ITEMS = 80;
   localparam int PHASE_ITEMS  = 16;
   localparam int HOLD_CYCLES  = 400;

   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
      logic               last_of_run;
      logic               image_done;
   } pixel_type;

   // Tracks decoder state and queues the pixels each accepted transaction should produce.
   class pixel_tracker;
      logic [RGB_W-1:0]      palette [PAL_DEPTH];
      logic [BYTE_W-1:0]     planes [2*DEF_MAX_WIDTH];
      int unsigned           line_pos, row_cnt, run_len;
      bit                    run_pending, mode24;
      logic [CSR_DATA_W-1:0] width_reg, height_reg;
      pixel_type             pending_pixels [$];

      function new();
         mode24      = 1'b0;
         width_reg   = CSR_DATA_W'(DIM_RESET);
         height_reg  = CSR_DATA_W'(DIM_RESET);
         line_pos    = 0;
         row_cnt     = 0;
         run_len     = 0;
         run_pending = 1'b0;
      endfunction

      function int unsigned clamp_dim(logic [CSR_DATA_W-1:0] v, int unsigned maxv);
         if (v == 0) return 1;
         if (v > maxv) return maxv;
         return 32'(v);
      endfunction

      function bit image_finished();
         return row_cnt >= clamp_dim(height_reg, DEF_MAX_HEIGHT);
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_COLOR_MODE:   mode24 = val[0];
            CSR_IMAGE_WIDTH:  width_reg = val;
            CSR_IMAGE_HEIGHT: height_reg = val;
            default: ;
         endcase
      endfunction

      function logic [COLOR_W-1:0] pack565(logic [RGB_W-1:0] rgb);
         return {rgb[23:19], rgb[15:10], rgb[7:3]};
      endfunction

      function void take_request(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] value,
                                 logic [BYTE_W-1:0] idx, logic [RGB_W-1:0] rgb);
         int unsigned w, h, line_len, count, col, r;
         pixel_type   pix, held;
         bit          have_held, emit, line_end;
         w         = clamp_dim(width_reg, DEF_MAX_WIDTH);
         h         = clamp_dim(height_reg, DEF_MAX_HEIGHT);
         line_len  = mode24 ? 3*w : w;
         have_held = 1'b0;
         case (cmd)
            CMD_PALETTE: begin
               palette[idx] = rgb;
               return;
            end
            CMD_NEW_IMAGE: begin
               line_pos    = 0;
               row_cnt     = 0;
               run_pending = 1'b0;
               run_len     = 0;
               return;
            end
            CMD_DATA: ;
            default: return;
         endcase
         if (row_cnt >= h) return;
         if (run_pending) begin
            count       = run_len;
            run_pending = 1'b0;
         end else if ((value & RUN_MARK) == RUN_MARK) begin
            run_pending = 1'b1;
            run_len     = 32'(value & RUN_COUNT_MASK);
            return;
         end else begin
            count = 1;
         end
         for (int k = 0; k < count; k++) begin
            emit     = 1'b0;
            line_end = 1'b0;
            col      = 0;
            // position left past the line by a register change
            if (line_pos >= line_len) begin
               line_pos = 0;
               row_cnt++;
               if (row_cnt >= h) break;
            end
            if (!mode24) begin
               pix.color = pack565(palette[value]);
               col       = line_pos;
               emit      = 1'b1;
            end else if (line_pos < 2*w) begin
               planes[line_pos] = value;
            end else begin
               col       = line_pos - 2*w;
               pix.color = pack565({planes[col], planes[col + w], value});
               emit      = 1'b1;
            end
            line_pos++;
            if (line_pos >= line_len) begin
               line_pos = 0;
               row_cnt++;
               line_end = 1'b1;
            end
            if (emit) begin
               if (have_held) pending_pixels.push_back(held);
               r               = line_end ? row_cnt - 1 : row_cnt;
               pix.column      = col[COORD_W-1:0];
               pix.row         = r[COORD_W-1:0];
               pix.last_of_run = 1'b0;
               pix.image_done  = line_end && (row_cnt >= h);
               held            = pix;
               have_held       = 1'b1;
            end
            // rest of the run is dropped at the line end
            if (line_end) break;
         end
         if (have_held) begin
            held.last_of_run = 1'b1;
            pending_pixels.push_back(held);
         end
      endfunction

      function string match_pixel(pixel_type got);
         pixel_type want;
         string     diff;
         if (pending_pixels.size() == 0)
            return $sformatf("unexpected pixel: color %h col %0d row %0d",
                             got.color, got.column, got.row);
         want = pending_pixels.pop_front();
         diff = "";
         if (got.color !== want.color)
            diff = {diff, $sformatf(" color %h exp %h", got.color, want.color)};
         if (got.column !== want.column)
            diff = {diff, $sformatf(" column %0d exp %0d", got.column, want.column)};
         if (got.row !== want.row)
            diff = {diff, $sformatf(" row %0d exp %0d", got.row, want.row)};
         if (got.last_of_run !== want.last_of_run)
            diff = {diff, $sformatf(" last_of_run %b exp %b", got.last_of_run,
                                    want.last_of_run)};
         if (got.image_done !== want.image_done)
            diff = {diff, $sformatf(" image_done %b exp %b", got.image_done, want.image_done)};
         if (diff != "")
            diff = {$sformatf("pixel col %0d row %0d:", want.column, want.row), diff};
         return diff;
      endfunction
   endclass

   logic clock;
   logic reset;
   int   idle_pct;
   int   stall_pct;
   int   hold_cycles;
   int   error_count;
   int   work_items;

   pixel_tracker pixels = new();

   pcx_rle_req_if req_if ();
   pcx_rle_rsp_if rsp_if ();
   pcx_rle_csr_if csr_if ();

   pcx_rle_image_decoder_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Some tests failed");
      $finish;
   end

   task automatic report_mismatch(string msg);
      if (error_count < 50) $display("MISMATCH @%0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic set_traffic(int sel);
      case (sel)
         0: begin idle_pct = 0;  stall_pct = 0;  end
         1: begin idle_pct = 84; stall_pct = 0;  end
         2: begin idle_pct = 0;  stall_pct = 84; end
         default: begin idle_pct = 32; stall_pct = 32; end
      endcase
   endtask

   task automatic send_item(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] value,
                            logic [BYTE_W-1:0] idx, logic [RGB_W-1:0] rgb);
      bit counts;
      counts = (cmd != CMD_UNUSED) && !(cmd == CMD_DATA && pixels.image_finished());
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.command       <= cmd;
      req_if.data_byte     <= value;
      req_if.palette_index <= idx;
      req_if.palette_rgb   <= rgb;
      do @(posedge clock); while (!req_if.ready);
      pixels.take_request(cmd, value, idx, rgb);
      if (counts) work_items++;
   endtask

   // command with a random payload
   task automatic send_cmd(logic [CMD_W-1:0] cmd);
      send_item(cmd, BYTE_W'($urandom), BYTE_W'($urandom), RGB_W'($urandom));
   endtask

   task automatic send_data(logic [BYTE_W-1:0] value);
      send_item(CMD_DATA, value, BYTE_W'($urandom), RGB_W'($urandom));
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_if.valid     <= 1'b1;
      csr_if.reg_index <= idx;
      csr_if.wdata     <= val;
      do @(posedge clock); while (!csr_if.ready);
      pixels.write_reg(idx, val);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_pixels_out();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pixels.pending_pixels.size() != 0);
   endtask

   // a transaction with no pixels may still be in flight, so stay quiet a while
   task automatic settle();
      wait_pixels_out();
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic run_random_phase(int phase);
      logic [CSR_DATA_W-1:0] w, h;
      logic [BYTE_W-1:0]     mark;
      bit                    mode;
      int                    start, pick;
      set_traffic(phase % 4);
      case (phase)
         0: begin mode = 1'b0; w = 11'd2047; h = 11'd1;    end
         1: begin mode = 1'b1; w = 11'd0;    h = 11'd2047; end
         2: begin mode = 1'b0; w = 11'd16;   h = 11'd8;    end
         3: begin mode = 1'b1; w = 11'd1024; h = 11'd0;    end
         default: begin
            mode = 1'($urandom_range(1));
            pick = $urandom_range(9);
            w = (pick == 0) ? 11'd0 : (pick == 1) ? 11'd2047 : (pick == 2) ? 11'd1024 :
                CSR_DATA_W'($urandom_range(1, 16));
            pick = $urandom_range(9);
            h = (pick == 0) ? 11'd0 : (pick == 1) ? 11'd2047 : (pick == 2) ? 11'd1024 :
                CSR_DATA_W'($urandom_range(1, 6));
            if (w > 16 && h > 6) h = CSR_DATA_W'($urandom_range(1, 2));
         end
      endcase
      csr_write(CSR_COLOR_MODE, CSR_DATA_W'(mode));
      csr_write(CSR_IMAGE_WIDTH, w);
      csr_write(CSR_IMAGE_HEIGHT, h);
      // now and then keep the old position so a shrunken line takes effect
      if (phase < 4 || $urandom_range(3) != 0)
         send_cmd(CMD_NEW_IMAGE);
      if (phase == 2) hold_cycles = HOLD_CYCLES;
      start = work_items;
      while (!pixels.image_finished() && work_items - start < PHASE_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            send_data(BYTE_W'($urandom_range('hbf)));
         end else if (pick < 85) begin
            mark = ($urandom_range(9) == 0) ? RUN_MARK :
                   RUN_MARK | BYTE_W'($urandom_range(RUN_COUNT_MASK));
            send_data(mark);
            if ($urandom_range(19) == 0) send_cmd(CMD_PALETTE);
            send_data(BYTE_W'($urandom));
         end else if (pick < 92) begin
            send_cmd(CMD_PALETTE);
         end else if (pick < 95) begin
            send_cmd(CMD_UNUSED);
         end else if (pick < 98) begin
            // marker cut off by a new image
            send_data(RUN_MARK | BYTE_W'($urandom_range(RUN_COUNT_MASK)));
            send_cmd(CMD_NEW_IMAGE);
         end else begin
            wait_pixels_out();
         end
      end
      if ($urandom_range(1)) send_data(BYTE_W'($urandom));
      settle();
   endtask

   // pixel sink: checks each transaction and drives ready
   initial begin
      pixel_type got;
      string     msg;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            got.color       = rsp_if.pixel_color;
            got.column      = rsp_if.pixel_column;
            got.row         = rsp_if.pixel_row;
            got.last_of_run = rsp_if.last_of_run;
            got.image_done  = rsp_if.image_done;
            msg = pixels.match_pixel(got);
            if (msg != "") report_mismatch(msg);
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   initial begin
      int start, phase;
      error_count = 0;
      work_items  = 0;
      hold_cycles = 0;
      set_traffic(0);
      reset                <= 1'b1;
      req_if.valid         <= 1'b0;
      req_if.command       <= CMD_DATA;
      req_if.data_byte     <= '0;
      req_if.palette_index <= '0;
      req_if.palette_rgb   <= '0;
      csr_if.valid         <= 1'b0;
      csr_if.reg_index     <= CSR_COLOR_MODE;
      csr_if.wdata         <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // fill the whole palette and both stored planes so no read hits an unwritten entry
      for (int i = 0; i < PAL_DEPTH; i++)
         send_item(CMD_PALETTE, BYTE_W'($urandom), BYTE_W'(i), RGB_W'($urandom));
      settle();
      csr_write(CSR_COLOR_MODE, 1);
      send_cmd(CMD_NEW_IMAGE);
      repeat (32) begin
         send_data(RUN_MARK | RUN_COUNT_MASK);
         send_data(BYTE_W'($urandom));
      end
      send_data(RUN_MARK | 8'd32);
      send_data(BYTE_W'($urandom));
      settle();

      // palette mode, 5 x 3
      set_traffic(3);
      csr_write(CSR_COLOR_MODE, 0);
      csr_write(CSR_IMAGE_WIDTH, 5);
      csr_write(CSR_IMAGE_HEIGHT, 3);
      send_cmd(CMD_NEW_IMAGE);
      send_item(CMD_PALETTE, BYTE_W'($urandom), 8'h00, 24'h000000);
      send_item(CMD_PALETTE, BYTE_W'($urandom), 8'hff, 24'hffffff);
      send_data(8'h00);
      send_data(8'hbf);
      send_data(8'h7f);
      send_data(RUN_MARK | 8'd3);           // runs over the line end
      send_data(8'hff);
      send_data(RUN_MARK);                  // zero count
      send_data(8'h55);
      send_data(RUN_MARK | 8'd2);
      send_item(CMD_PALETTE, BYTE_W'($urandom), 8'h01, RGB_W'($urandom));
      send_data(8'h01);
      send_cmd(CMD_UNUSED);
      send_data(RUN_MARK | RUN_COUNT_MASK);
      send_data(8'h80);
      send_data(RUN_MARK | RUN_COUNT_MASK);
      send_data(8'h40);
      send_data(8'h12);                     // after the last row
      settle();

      // shrink the line under the current position
      send_cmd(CMD_NEW_IMAGE);
      send_data(8'h10);
      send_data(8'h20);
      send_data(8'h30);
      settle();
      csr_write(CSR_IMAGE_WIDTH, 2);
      send_data(8'h40);
      settle();
      csr_write(CSR_IMAGE_WIDTH, 1);
      csr_write(CSR_IMAGE_HEIGHT, 2);
      send_data(8'h50);
      settle();

      // 24-bit mode, 2 x 1
      csr_write(CSR_COLOR_MODE, 1);
      csr_write(CSR_IMAGE_WIDTH, 2);
      csr_write(CSR_IMAGE_HEIGHT, 1);
      send_cmd(CMD_NEW_IMAGE);
      send_data(RUN_MARK | 8'd4);
      send_data(8'h77);
      send_data(RUN_MARK | 8'd2);
      send_data(8'h99);
      settle();

      start = work_items;
      phase = 0;
      while (work_items - start < RANDOM_ITEMS) begin
         run_random_phase(phase);
         phase++;
      end

      settle();
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
